/* hw/rtl/qcse_pkg.sv */
// Shared types and constants for the quadrature counter speed estimator.
`timescale 1ns / 1ps

package qcse_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int STAMP_DEPTH_DEFAULT = 4;

    localparam int NUM_W   = 48;
    localparam int STAMP_W = 32;
    localparam int OUT_W   = 32;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Opcodes
    localparam logic [1:0] OP_EDGE_A = 2'd0;
    localparam logic [1:0] OP_EDGE_B = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_REVERSE  = 2'd0;
    localparam logic [1:0] REG_MIN_SPAN = 2'd1;
    localparam logic [1:0] REG_NUMER    = 2'd2;
    localparam logic [1:0] REG_KEEP     = 2'd3;

    // Register reset values
    localparam logic        REVERSE_RST  = 1'b0;
    localparam logic [15:0] MIN_SPAN_RST = 16'd50;
    localparam logic [47:0] NUMER_RST    = 48'd66772528302;
    localparam logic [15:0] KEEP_RST     = 16'd60948;

    // Direction codes
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_FWD  = 2'b01;
    localparam logic [1:0] DIR_REV  = 2'b11;

    localparam logic [31:0] MAG_MAX  = 32'h7FFF_FFFF;
    localparam logic [16:0] KEEP_ONE = 17'h1_0000;

    typedef struct packed {
        logic accept;
        logic check;
        logic div_step;
        logic mul1;
        logic mul2;
        logic load_out;
    } qcse_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic span_ok;
        logic div_last;
    } qcse_status_t;

endpackage

/* hw/rtl/qcse_ctrl.sv */
// Sequencer for the quadrature counter speed estimator.
`timescale 1ns / 1ps

module qcse_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  qcse_pkg::qcse_status_t status,
    output qcse_pkg::qcse_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_MUL1  = 6'b001000,
        S_MUL2  = 6'b010000,
        S_POST  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.is_tick ? S_CHECK : S_POST;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.span_ok ? S_DIV : S_POST;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_POST;
            end
            S_POST:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/qcse_dp.sv */
// Datapath: counter, stamp history, divider, filter and result registers.
`timescale 1ns / 1ps

module qcse_dp
#(
    parameter int COUNT_WIDTH = qcse_pkg::COUNT_WIDTH_DEFAULT,
    parameter int STAMP_DEPTH = qcse_pkg::STAMP_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  qcse_pkg::qcse_cmd_t    cmd,
    output qcse_pkg::qcse_status_t status,
    input  logic [1:0]             opcode,
    input  logic                   level_a,
    input  logic                   level_b,
    input  logic [31:0]            time_us,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [47:0]            cfg_data,
    output logic signed [31:0]     position_count,
    output logic signed [31:0]     window_delta,
    output logic signed [1:0]      direction,
    output logic signed [31:0]     speed,
    output logic                   speed_updated
);

    localparam int NUM_W = qcse_pkg::NUM_W;
    localparam int CW    = qcse_pkg::DIV_CNT_W;

    // Configuration
    logic        reverse_reg;
    logic [15:0] min_span_reg;
    logic [47:0] numer_reg;
    logic [15:0] keep_reg;

    // Architectural state
    logic [31:0]            stamps_reg [STAMP_DEPTH];
    logic [COUNT_WIDTH-1:0] position_reg;
    logic [COUNT_WIDTH-1:0] win_start_reg;
    logic [COUNT_WIDTH-1:0] win_delta_reg;
    logic [1:0]             dir_reg;
    logic signed [31:0]     speed_reg;

    // Working registers
    logic [31:0]          now_reg;
    logic [31:0]          span_reg;
    logic [31:0]          rem_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [CW-1:0]        div_cnt_reg;
    logic signed [48:0]   prod_reg;
    logic signed [31:0]   raw_reg;
    logic                 updated_reg;

    // Result registers
    logic [31:0] out_position_reg;
    logic [31:0] out_delta_reg;
    logic [1:0]  out_dir_reg;
    logic [31:0] out_speed_reg;
    logic        out_updated_reg;

    logic                   is_edge;
    logic                   count_up;
    logic [COUNT_WIDTH-1:0] position_next;
    logic [31:0]            oldest;
    logic [31:0]            hist_span;
    logic [31:0]            since;
    logic [31:0]            span_max;
    logic                   span_ok;
    logic [32:0]            shifted;
    logic [32:0]            diff;
    logic                   fits;
    logic [31:0]            mag;
    logic signed [31:0]     raw;
    logic signed [16:0]     keep_s;
    logic [16:0]            gain;
    logic signed [17:0]     gain_s;
    logic signed [50:0]     blend;
    logic [63:0]            pos_ext;
    logic [63:0]            delta_ext;

    assign is_edge = (opcode == qcse_pkg::OP_EDGE_A) || (opcode == qcse_pkg::OP_EDGE_B);

    always_comb
    begin
        if (opcode == qcse_pkg::OP_EDGE_A)
        begin
            count_up = (level_a != level_b) ^ reverse_reg;
        end
        else
        begin
            count_up = (level_a == level_b) ^ reverse_reg;
        end
        position_next = count_up ? position_reg + 1'b1 : position_reg - 1'b1;
    end

    // Span check: span of the stamp history, stretched to time since oldest stamp
    assign oldest    = stamps_reg[0];
    assign hist_span = stamps_reg[STAMP_DEPTH-1] - oldest;
    assign since     = now_reg - oldest;
    assign span_max  = (hist_span < since) ? since : hist_span;
    assign span_ok   = (oldest != 32'd0) && (span_max != 32'd0)
                       && (span_max >= {16'd0, min_span_reg});

    // Restoring divider, one quotient bit per step
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, span_reg};
    assign fits    = (shifted >= {1'b0, span_reg});

    assign mag = (quo_reg > NUM_W'(qcse_pkg::MAG_MAX)) ? qcse_pkg::MAG_MAX : quo_reg[31:0];

    always_comb
    begin
        case (dir_reg)
            qcse_pkg::DIR_FWD: raw = $signed(mag);
            qcse_pkg::DIR_REV: raw = -$signed(mag);
            default:           raw = 32'sd0;
        endcase
    end

    assign keep_s = $signed({1'b0, keep_reg});
    assign gain   = qcse_pkg::KEEP_ONE - {1'b0, keep_reg};
    assign gain_s = $signed({1'b0, gain});
    assign blend  = 51'(prod_reg) + gain_s * raw_reg + 51'sd32768;

    assign status.is_tick  = (opcode == qcse_pkg::OP_TICK);
    assign status.span_ok  = span_ok;
    assign status.div_last = (div_cnt_reg == '0);

    assign pos_ext   = 64'(position_reg);
    assign delta_ext = 64'(win_delta_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg  <= qcse_pkg::REVERSE_RST;
            min_span_reg <= qcse_pkg::MIN_SPAN_RST;
            numer_reg    <= qcse_pkg::NUMER_RST;
            keep_reg     <= qcse_pkg::KEEP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                qcse_pkg::REG_REVERSE:  reverse_reg  <= cfg_data[0];
                qcse_pkg::REG_MIN_SPAN: min_span_reg <= cfg_data[15:0];
                qcse_pkg::REG_NUMER:    numer_reg    <= cfg_data;
                qcse_pkg::REG_KEEP:     keep_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAMP_DEPTH; i++)
            begin
                stamps_reg[i] <= '0;
            end
            position_reg  <= '0;
            win_start_reg <= '0;
            win_delta_reg <= '0;
            dir_reg       <= qcse_pkg::DIR_NONE;
            speed_reg     <= '0;
            updated_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                updated_reg <= 1'b0;
                if (is_edge)
                begin
                    for (int i = 0; i < STAMP_DEPTH - 1; i++)
                    begin
                        stamps_reg[i] <= stamps_reg[i+1];
                    end
                    stamps_reg[STAMP_DEPTH-1] <= time_us;
                    position_reg <= position_next;
                    dir_reg      <= count_up ? qcse_pkg::DIR_FWD : qcse_pkg::DIR_REV;
                end
                else if (opcode == qcse_pkg::OP_TICK)
                begin
                    win_delta_reg <= position_reg - win_start_reg;
                    win_start_reg <= position_reg;
                end
            end
            if (cmd.check)
            begin
                updated_reg <= span_ok;
            end
            if (cmd.mul2)
            begin
                speed_reg <= blend[47:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            now_reg <= time_us;
        end
        if (cmd.check)
        begin
            span_reg    <= span_max;
            rem_reg     <= '0;
            quo_reg     <= numer_reg;
            div_cnt_reg <= CW'(qcse_pkg::DIV_STEPS - 1);
        end
        if (cmd.div_step)
        begin
            rem_reg     <= fits ? diff[31:0] : shifted[31:0];
            quo_reg     <= {quo_reg[NUM_W-2:0], fits};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
        if (cmd.mul1)
        begin
            prod_reg <= keep_s * speed_reg;
            raw_reg  <= raw;
        end
        if (cmd.load_out)
        begin
            out_position_reg <= pos_ext[31:0];
            out_delta_reg    <= delta_ext[31:0];
            out_dir_reg      <= dir_reg;
            out_speed_reg    <= speed_reg;
            out_updated_reg  <= updated_reg;
        end
    end

    assign position_count = $signed(out_position_reg);
    assign window_delta   = $signed(out_delta_reg);
    assign direction      = $signed(out_dir_reg);
    assign speed          = $signed(out_speed_reg);
    assign speed_updated  = out_updated_reg;

endmodule

/* hw/rtl/quadrature_counter_speed_estimator_core.sv */
// Top level of the quadrature counter speed estimator.
`timescale 1ns / 1ps

// Sequence: an edge or unused opcode goes from the input transfer to the post state, where
//   the result is registered; a tick passes through the span check first, and on through the
//   48-step restoring divider and two filter multiply steps when the speed is updated.
// Flow: one item at a time; the next transfer is taken the cycle after the result
//   is loaded, and the result waits in the post state while the output slot is full.
// Reset: asynchronous; clears history, counters and speed, loads register defaults.

module quadrature_counter_speed_estimator_core
#(
    parameter int COUNT_WIDTH = qcse_pkg::COUNT_WIDTH_DEFAULT,
    parameter int STAMP_DEPTH = qcse_pkg::STAMP_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic               level_a,
    input  logic               level_b,
    input  logic [31:0]        time_us,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] position_count,
    output logic signed [31:0] window_delta,
    output logic signed [1:0]  direction,
    output logic signed [31:0] speed,
    output logic               speed_updated,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_data
);

    qcse_pkg::qcse_cmd_t    cmd;
    qcse_pkg::qcse_status_t status;

    qcse_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    qcse_dp
    #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .STAMP_DEPTH (STAMP_DEPTH)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .opcode         (opcode),
        .level_a        (level_a),
        .level_b        (level_b),
        .time_us        (time_us),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .position_count (position_count),
        .window_delta   (window_delta),
        .direction      (direction),
        .speed          (speed),
        .speed_updated  (speed_updated)
    );

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.check, cmd.div_step, cmd.mul1, cmd.mul2, cmd.load_out}))
        else $error("more than one datapath command active");

    a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul1 |-> ($past(cmd.div_step) && $past(status.div_last)))
        else $error("filter started before the divider finished");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (direction != 2'sb10))
        else $error("invalid direction code on result");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input transfer taken while an item is in progress");
`endif

endmodule
